[hw/rtl/mod_exp_pkg.sv]
package mod_exp_pkg;

	localparam int MOD_W = 31;
	localparam int EXP_W = 32;
	localparam int CNT_W = $clog2(MOD_W);
	localparam int SUM_W = MOD_W + 2;
	localparam int IN_TDATA_W = ((MOD_W + EXP_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((MOD_W + 7) / 8) * 8;

	localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(998244353);

	// One request to the bit-serial modular multiplier.
	typedef struct packed {
		logic             start;
		logic [MOD_W-1:0] x;
		logic [MOD_W-1:0] y;
	} mul_req_t;

	typedef struct packed {
		logic             done;
		logic [MOD_W-1:0] value;
	} mul_rsp_t;

endpackage

[hw/rtl/modular_exponentiation.sv]
// Right-to-left square-and-multiply over one shared bit-serial modular multiplier.
// Each multiplication runs 31 one-bit steps and then raises a registered done.
// An exponent of zero skips the multiplier and goes straight to the output.
// One request is in work at a time; the next is taken while a finished result waits.
// arst_n clears the control state and sets the modulus to 998244353.
module modular_exponentiation (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_wr_en,
	input  logic [mod_exp_pkg::MOD_W-1:0]          cfg_wr_data,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	// Fields from bit 0: base (31), exponent (32), zero padding.
	input  logic [mod_exp_pkg::IN_TDATA_W-1:0]     s_tdata,
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	// Fields from bit 0: power_mod (31), zero padding.
	output logic [mod_exp_pkg::OUT_TDATA_W-1:0]    m_tdata
);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_RED  = 6'b000010,
		S_BIT  = 6'b000100,
		S_MUL  = 6'b001000,
		S_SQR  = 6'b010000,
		S_OUT  = 6'b100000
	} state_t;

	state_t                          state_q;
	state_t                          state_d;
	logic [mod_exp_pkg::MOD_W-1:0]   modulus_q;
	logic [mod_exp_pkg::MOD_W-1:0]   mod_q;
	logic [mod_exp_pkg::MOD_W-1:0]   acc_q;
	logic [mod_exp_pkg::MOD_W-1:0]   pw_q;
	logic [mod_exp_pkg::EXP_W-1:0]   exp_q;
	logic [mod_exp_pkg::MOD_W-1:0]   out_q;
	logic                            out_valid_q;
	logic                            out_free;
	logic [mod_exp_pkg::MOD_W-1:0]   in_base;
	logic [mod_exp_pkg::EXP_W-1:0]   in_exp;
	mod_exp_pkg::mul_req_t           req;
	mod_exp_pkg::mul_rsp_t           rsp;

	assign in_base  = s_tdata[mod_exp_pkg::MOD_W-1:0];
	assign in_exp   = s_tdata[mod_exp_pkg::MOD_W+mod_exp_pkg::EXP_W-1:mod_exp_pkg::MOD_W];
	assign s_tready = (state_q == S_IDLE);
	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(mod_exp_pkg::OUT_TDATA_W - mod_exp_pkg::MOD_W){1'b0}}, out_q};

	mod_exp_mulmod u_mulmod (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.modulus (mod_q),
		.rsp     (rsp)
	);

	always_comb begin
		state_d   = state_q;
		req.start = 1'b0;
		req.x     = pw_q;
		req.y     = pw_q;
		unique case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					if (in_exp == '0) begin
						state_d = S_OUT;
					end else begin
						// The base is reduced by multiplying it by one.
						req.start = 1'b1;
						req.x     = in_base;
						req.y     = mod_exp_pkg::MOD_W'(1);
						state_d   = S_RED;
					end
				end
			end
			S_RED: begin
				if (rsp.done) begin
					state_d = S_BIT;
				end
			end
			S_BIT: begin
				if (exp_q == '0) begin
					state_d = S_OUT;
				end else if (exp_q[0]) begin
					req.start = 1'b1;
					req.x     = acc_q;
					state_d   = S_MUL;
				end else begin
					req.start = 1'b1;
					state_d   = S_SQR;
				end
			end
			S_MUL: begin
				if (rsp.done) begin
					req.start = 1'b1;
					state_d   = S_SQR;
				end
			end
			S_SQR: begin
				if (rsp.done) begin
					state_d = S_BIT;
				end
			end
			S_OUT: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			modulus_q   <= mod_exp_pkg::MOD_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_wr_en) begin
				modulus_q <= cfg_wr_data;
			end
			if (state_q == S_OUT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				exp_q <= in_exp;
				acc_q <= mod_exp_pkg::MOD_W'(1);
				// A modulus of zero behaves as a modulus of one.
				mod_q <= (modulus_q == '0) ? mod_exp_pkg::MOD_W'(1) : modulus_q;
			end
			S_RED: begin
				if (rsp.done) begin
					pw_q <= rsp.value;
				end
			end
			S_MUL: begin
				if (rsp.done) begin
					acc_q <= rsp.value;
				end
			end
			S_SQR: begin
				if (rsp.done) begin
					pw_q  <= rsp.value;
					exp_q <= exp_q >> 1;
				end
			end
			S_OUT: begin
				if (out_free) begin
					out_q <= acc_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

[hw/rtl/mod_exp_mulmod.sv]
module mod_exp_mulmod (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mod_exp_pkg::mul_req_t            req,
	input  logic [mod_exp_pkg::MOD_W-1:0]    modulus,
	output mod_exp_pkg::mul_rsp_t            rsp
);

	logic [mod_exp_pkg::MOD_W-1:0] x_q;
	logic [mod_exp_pkg::MOD_W-1:0] y_q;
	logic [mod_exp_pkg::MOD_W-1:0] r_q;
	logic [mod_exp_pkg::CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic                          done_q;

	logic [mod_exp_pkg::SUM_W-1:0] sum;
	logic [mod_exp_pkg::SUM_W-1:0] mod_ext;
	logic [mod_exp_pkg::SUM_W-1:0] mod_twice;
	logic [mod_exp_pkg::SUM_W-1:0] sum_red;

	// Interleaved multiply, multiplier bits taken MSB first. With r and y below the
	// modulus, 2r + y stays below three times it, so at most two subtractions are needed.
	always_comb begin
		mod_ext   = {2'b00, modulus};
		mod_twice = {1'b0, modulus, 1'b0};
		sum = {1'b0, r_q, 1'b0} + (x_q[mod_exp_pkg::MOD_W-1] ? {2'b00, y_q} : '0);
		priority if (sum >= mod_twice) begin
			sum_red = sum - mod_twice;
		end else if (sum >= mod_ext) begin
			sum_red = sum - mod_ext;
		end else begin
			sum_red = sum;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == '0) && !req.start;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= mod_exp_pkg::CNT_W'(mod_exp_pkg::MOD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= req.x;
			y_q <= req.y;
			r_q <= '0;
		end else if (busy_q) begin
			x_q <= {x_q[mod_exp_pkg::MOD_W-2:0], 1'b0};
			r_q <= sum_red[mod_exp_pkg::MOD_W-1:0];
		end
	end

	assign rsp.done  = done_q;
	assign rsp.value = r_q;

endmodule
